>>> rtl/gbps_pkg.sv
package gbps_pkg;

  // Array size along one side of the grid
  localparam int MAX_SIDE_DEF = 64;

  // Field widths
  localparam int COORD_W  = 6;
  localparam int SIDE_W   = 7;
  localparam int LEN_W    = 12;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Stream payload layout
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 32;
  localparam int M_USED_W  = 1 + 2 * LEN_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SIDE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y     = 3'd4;

  localparam logic [SIDE_W-1:0]  GRID_SIDE_RST = 7'd64;
  localparam logic [COORD_W-1:0] START_RST     = 6'd0;
  localparam logic [COORD_W-1:0] END_RST       = 6'd63;

  // Item kinds carried on tuser
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam int DIR_W = 2;
  typedef enum logic [DIR_W-1:0] {
    DIR_WEST  = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_NORTH = 2'd2,
    DIR_SOUTH = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_RST_CLEAR,
    ST_IDLE,
    ST_VIS_CLEAR,
    ST_INIT,
    ST_POP,
    ST_LOAD,
    ST_PROBE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic wall_wr;
    logic sweep;
    logic sweep_walls;
    logic init;
    logic pop;
    logic load;
    logic probe;
    dir_t dir;
    logic eval_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic off_grid;
    logic same_cell;
    logic found;
    logic more;
  } dp_status_t;

endpackage

>>> rtl/gbps_ram.sv
module gbps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gbps_ctrl.sv
module gbps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_action,
  output logic                 s_tready,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  input  gbps_pkg::dp_status_t status,
  output gbps_pkg::dp_cmd_t    cmd
);
  import gbps_pkg::*;

  state_t state, state_next;
  dir_t   dir, dir_next;
  logic   m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RST_CLEAR;
      dir      <= DIR_WEST;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      dir      <= dir_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    dir_next   = dir;
    cmd        = '0;
    cmd.dir    = dir;
    s_tready   = 1'b0;
    case (state)
      ST_RST_CLEAR: begin
        cmd.sweep       = 1'b1;
        cmd.sweep_walls = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_action == ACT_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = (status.off_grid || status.same_cell) ? ST_DONE : ST_VIS_CLEAR;
          end else begin
            cmd.wall_wr = 1'b1;
          end
        end
      end
      ST_VIS_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_POP;
      end
      ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        dir_next   = DIR_WEST;
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe   = 1'b1;
        cmd.eval_en = 1'b1;
        dir_next    = dir_t'(DIR_W'(dir) + DIR_W'(1));
        if (status.found) begin
          state_next = ST_DONE;
        end else if (dir == DIR_SOUTH) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.eval_en = 1'b1;
        if (status.found || !status.more) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

endmodule

>>> rtl/gbps_datapath.sv
module gbps_datapath #(
  parameter int MAX_SIDE = gbps_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [gbps_pkg::COORD_W-1:0]    cell_x,
  input  logic [gbps_pkg::COORD_W-1:0]    cell_y,
  input  logic                            wall,
  input  gbps_pkg::dp_cmd_t               cmd,
  output gbps_pkg::dp_status_t            status,
  output logic                            reached,
  output logic [gbps_pkg::LEN_W-1:0]      path_length,
  output logic [gbps_pkg::LEN_W-1:0]      cells_queued
);
  import gbps_pkg::*;

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int TW    = AW + 1;
  localparam int GW    = $clog2(MAX_SIDE + 1);
  localparam int CMP_W = (GW > SIDE_W) ? GW : SIDE_W;
  localparam int EXT_W = (TW > LEN_W) ? TW : LEN_W;

  // Configuration registers
  logic [SIDE_W-1:0]  grid_side;
  logic [COORD_W-1:0] start_x, start_y, end_x, end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= GRID_SIDE_RST;
      start_x   <= START_RST;
      start_y   <= START_RST;
      end_x     <= END_RST;
      end_y     <= END_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_SIDE: grid_side <= cfg_data;
        CFG_START_X:   start_x   <= cfg_data[COORD_W-1:0];
        CFG_START_Y:   start_y   <= cfg_data[COORD_W-1:0];
        CFG_END_X:     end_x     <= cfg_data[COORD_W-1:0];
        CFG_END_Y:     end_y     <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped side and endpoint checks
  logic [CMP_W-1:0] side_ext, max_ext, g;
  logic [AW-1:0]    s_idx, e_idx, wr_idx;
  logic             wr_in_range;

  always_comb begin
    side_ext = CMP_W'(grid_side);
    max_ext  = CMP_W'(MAX_SIDE);
    if (side_ext < CMP_W'(2)) begin
      g = CMP_W'(2);
    end else if (side_ext > max_ext) begin
      g = max_ext;
    end else begin
      g = side_ext;
    end
  end

  assign s_idx  = {CW'(start_y), CW'(start_x)};
  assign e_idx  = {CW'(end_y), CW'(end_x)};
  assign wr_idx = {CW'(cell_y), CW'(cell_x)};
  assign wr_in_range = (CMP_W'(cell_x) < max_ext) && (CMP_W'(cell_y) < max_ext);

  // Search registers
  logic [AW-1:0]    sweep_addr;
  logic [TW-1:0]    head, tail, tail_next;
  logic [AW-1:0]    p, pn;
  logic [LEN_W-1:0] dp, d, len_r;
  logic             pv, reached_r;

  // Memory read data
  logic             wall_rd, vis_rd;
  logic [LEN_W-1:0] dist_rd;
  logic [AW-1:0]    queue_rd;

  // Neighbor of the current cell in the probed direction
  logic [CW-1:0] px, py, nx, ny;
  logic [AW-1:0] n;
  logic          inb;

  assign px = p[CW-1:0];
  assign py = p[AW-1:CW];

  always_comb begin
    nx  = px;
    ny  = py;
    inb = 1'b0;
    case (cmd.dir)
      DIR_WEST: begin
        inb = (px != '0);
        nx  = px - CW'(1);
      end
      DIR_EAST: begin
        inb = (CMP_W'(px) + CMP_W'(1)) < g;
        nx  = px + CW'(1);
      end
      DIR_NORTH: begin
        inb = (py != '0);
        ny  = py - CW'(1);
      end
      DIR_SOUTH: begin
        inb = (CMP_W'(py) + CMP_W'(1)) < g;
        ny  = py + CW'(1);
      end
      default: ;
    endcase
  end

  assign n = {ny, nx};

  // Evaluate the probe issued in the previous cycle
  logic take, found, push;

  assign take  = cmd.eval_en && pv && !wall_rd && !vis_rd;
  assign d     = (dp == LEN_MAX) ? LEN_MAX : dp + LEN_W'(1);
  assign found = take && (pn == e_idx);
  assign push  = take && !found && (tail < TW'(DEPTH));

  always_comb begin
    if (cmd.start) begin
      tail_next = '0;
    end else if (cmd.init) begin
      tail_next = TW'(1);
    end else if (push) begin
      tail_next = tail + TW'(1);
    end else begin
      tail_next = tail;
    end
  end

  assign status.sweep_last = (sweep_addr == '1);
  assign status.off_grid   = (CMP_W'(start_x) >= g) || (CMP_W'(start_y) >= g) ||
                             (CMP_W'(end_x) >= g) || (CMP_W'(end_y) >= g);
  assign status.same_cell  = (s_idx == e_idx);
  assign status.found      = found;
  assign status.more       = (head < tail_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      head       <= '0;
      tail       <= '0;
      pv         <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (cmd.start) begin
        head <= '0;
      end else if (cmd.pop) begin
        head <= head + TW'(1);
      end
      tail <= tail_next;
      pv   <= cmd.probe && inb;
    end
  end

  // Saturate the queue count for the result
  logic [EXT_W-1:0] tail_ext;
  logic [LEN_W-1:0] queued_sat;

  assign tail_ext   = EXT_W'(tail);
  assign queued_sat = (tail_ext > EXT_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(tail_ext);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p <= queue_rd;
    end
    if (cmd.probe && (cmd.dir == DIR_WEST)) begin
      dp <= dist_rd;
    end
    pn <= n;
    if (cmd.start) begin
      reached_r <= status.same_cell && !status.off_grid;
      len_r     <= '0;
    end else if (found) begin
      reached_r <= 1'b1;
      len_r     <= d;
    end
    if (cmd.out_load) begin
      reached      <= reached_r;
      path_length  <= len_r;
      cells_queued <= queued_sat;
    end
  end

  // Memories
  gbps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_wall_ram (
    .clk   (clk),
    .we    ((cmd.sweep && cmd.sweep_walls) || (cmd.wall_wr && wr_in_range)),
    .waddr (cmd.sweep ? sweep_addr : wr_idx),
    .wdata (cmd.sweep ? 1'b0 : wall),
    .raddr (n),
    .rdata (wall_rd)
  );

  gbps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis_ram (
    .clk   (clk),
    .we    (cmd.sweep || cmd.init || take),
    .waddr (cmd.sweep ? sweep_addr : (cmd.init ? s_idx : pn)),
    .wdata (!cmd.sweep),
    .raddr (n),
    .rdata (vis_rd)
  );

  gbps_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_dist_ram (
    .clk   (clk),
    .we    (cmd.init || take),
    .waddr (cmd.init ? s_idx : pn),
    .wdata (cmd.init ? LEN_W'(0) : d),
    .raddr (queue_rd),
    .rdata (dist_rd)
  );

  gbps_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (cmd.init || push),
    .waddr (cmd.init ? AW'(0) : tail[AW-1:0]),
    .wdata (cmd.init ? s_idx : pn),
    .raddr (head[AW-1:0]),
    .rdata (queue_rd)
  );

endmodule

>>> rtl/grid_bfs_path_search_unit.sv
// Grid breadth-first path search, four neighbors.
//
// Input stream (s_*): one item per transfer. s_tuser selects the kind:
// a cell write stores one wall bit; a search runs a
// breadth-first search from the start cell to the end cell over open cells
// and produces one transfer on the output stream (m_*).
// Configuration (cfg_*): grid side, start and end cells; write only while idle.
//
// Operation: after reset the wall and visited maps are cleared, one entry a
// cycle, over the whole map; s_tready stays low meanwhile. A search whose
// endpoints lie off the grid or coincide goes straight to its answer. Any
// other search clears the visited map, seeds the queue, then steps through
// each dequeued cell (queue read, distance read, four neighbor probes, one
// drain), as set by the single read port of each map memory.
// One search is in flight at a time. The result sits in an output register,
// so a new item is taken while it waits; a stalled receiver only holds the
// next search at its end until the register frees up.
module grid_bfs_path_search_unit #(
  parameter int MAX_SIDE = gbps_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [gbps_pkg::S_TDATA_W-1:0]  s_tdata,  // cell_x[5:0], cell_y[11:6], wall[12]
  input  logic                            s_tuser,  // action: 0 cell write, 1 search
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gbps_pkg::M_TDATA_W-1:0]  m_tdata   // reached[0], path_length[12:1],
                                                    // cells_queued[24:13]
);
  import gbps_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             reached;
  logic [LEN_W-1:0] path_length, cells_queued;

  // Sequencer: handshakes, clearing sweeps and the search loop
  gbps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_action (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  // Maps, queue, distances and the result register
  gbps_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_x       (s_tdata[5:0]),
    .cell_y       (s_tdata[11:6]),
    .wall         (s_tdata[12]),
    .cmd          (cmd),
    .status       (status),
    .reached      (reached),
    .path_length  (path_length),
    .cells_queued (cells_queued)
  );

  // Pack the result, zero fill to whole bytes
  assign m_tdata = {(M_TDATA_W - M_USED_W)'(0), cells_queued, path_length, reached};

  // A nonzero path length comes only with a reached end cell
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || (m_tdata[12:1] == '0)))
    else $error("path length reported without reaching the end cell");

  // A full search blocks new items while it clears the visited map
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == ACT_SEARCH) &&
     !status.off_grid && !status.same_cell) |=> !s_tready)
    else $error("input taken while a search is starting");

  // Reset starts the wall map clearing pass
  assert property (@(posedge clk) $fell(rst) |-> !s_tready)
    else $error("input ready before the clearing pass");

endmodule
